[rtl/core/aesbc_pkg.sv]
// Shared types, constants and round functions of the AES block engine.
`default_nettype none
package aesbc_pkg;

    localparam int MAX_ROUNDS = 14;
    localparam int KEY_SLOTS  = MAX_ROUNDS + 1;
    localparam int KEY_AW     = $clog2(KEY_SLOTS);
    localparam int RND_W      = 4;
    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [1:0] {
        MODE_ECB     = 2'd0,
        MODE_CBC_ENC = 2'd1,
        MODE_CBC_DEC = 2'd2,
        MODE_SPARE   = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        CFG_MODE    = 2'd0,
        CFG_ROUNDS  = 2'd1,
        CFG_IV_HIGH = 2'd2,
        CFG_IV_LOW  = 2'd3
    } cfg_index_t;

    typedef enum logic {
        OP_KEY   = 1'b0,
        OP_BLOCK = 1'b1
    } opcode_t;

    typedef struct packed {
        logic [1:0]       mode;
        logic [RND_W-1:0] num_rounds;
        logic [127:0]     iv;
    } cfg_t;

    typedef struct packed {
        logic              is_block;
        logic              key_ok;
        logic [KEY_AW-1:0] idx;
        logic              first;
        logic [127:0]      data;
    } entry_t;

    typedef struct packed {
        logic   valid;
        entry_t entry;
    } item_t;

    typedef struct packed {
        logic busy;
        logic pop;
        logic pop_block;
    } eng_status_t;

    typedef logic [0:255][7:0] tbl_t;

    localparam tbl_t SBOX = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    // Inverse table, built at elaboration from the forward one.
    function automatic tbl_t build_inv();
        tbl_t t;
        t = '0;
        for (int i = 0; i < 256; i++)
        begin
            t[SBOX[i]] = 8'(i);
        end
        return t;
    endfunction

    localparam tbl_t INV_SBOX = build_inv();

    function automatic logic [7:0] xt(input logic [7:0] b);
        return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [7:0] get_byte(input logic [127:0] s, input int i);
        return s[127-8*i -: 8];
    endfunction

    function automatic logic [127:0] sub_shift(input logic [127:0] s);
        logic [127:0] t;
        t = '0;
        for (int c = 0; c < 4; c++)
        begin
            for (int r = 0; r < 4; r++)
            begin
                t[127-8*(r+4*c) -: 8] = SBOX[get_byte(s, r + 4*((c + r) % 4))];
            end
        end
        return t;
    endfunction

    function automatic logic [127:0] inv_sub_shift(input logic [127:0] s);
        logic [127:0] t;
        t = '0;
        for (int c = 0; c < 4; c++)
        begin
            for (int r = 0; r < 4; r++)
            begin
                t[127-8*(r+4*((c + r) % 4)) -: 8] = INV_SBOX[get_byte(s, r + 4*c)];
            end
        end
        return t;
    endfunction

    function automatic logic [127:0] mix(input logic [127:0] s, input logic inv);
        logic [127:0] t;
        logic [7:0]   a [4];
        logic [7:0]   x2 [4];
        logic [7:0]   x4 [4];
        logic [7:0]   x8 [4];
        logic [7:0]   v;
        t = '0;
        for (int c = 0; c < 4; c++)
        begin
            for (int r = 0; r < 4; r++)
            begin
                a[r]  = get_byte(s, r + 4*c);
                x2[r] = xt(a[r]);
                x4[r] = xt(x2[r]);
                x8[r] = xt(x4[r]);
            end
            for (int r = 0; r < 4; r++)
            begin
                if (inv)
                begin
                    v = (x8[r] ^ x4[r] ^ x2[r])
                      ^ (x8[(r+1)%4] ^ x2[(r+1)%4] ^ a[(r+1)%4])
                      ^ (x8[(r+2)%4] ^ x4[(r+2)%4] ^ a[(r+2)%4])
                      ^ (x8[(r+3)%4] ^ a[(r+3)%4]);
                end
                else
                begin
                    v = x2[r] ^ (x2[(r+1)%4] ^ a[(r+1)%4]) ^ a[(r+2)%4] ^ a[(r+3)%4];
                end
                t[127-8*(r+4*c) -: 8] = v;
            end
        end
        return t;
    endfunction

endpackage
`default_nettype wire

[rtl/core/aesbc_ram.sv]
// Generic single-port-write, registered-read RAM.
`default_nettype none
module aesbc_ram #(
    parameter int WIDTH = 128,
    parameter int DEPTH = 15
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;
endmodule
`default_nettype wire

[rtl/core/aesbc_front.sv]
// Front end: accepts input words, classifies them and queues them for the engine.
`default_nettype none
module aesbc_front (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire logic                  opcode,
    input  wire logic [3:0]            round_index,
    input  wire logic                  first_block,
    input  wire logic [63:0]           word_high,
    input  wire logic [63:0]           word_low,
    output aesbc_pkg::item_t           item,
    input  wire logic                  pop
);
    localparam int CW = $clog2(aesbc_pkg::QUEUE_DEPTH + 1);
    localparam int PW = $clog2(aesbc_pkg::QUEUE_DEPTH);

    aesbc_pkg::entry_t mem_reg [aesbc_pkg::QUEUE_DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    aesbc_pkg::entry_t in_entry;
    logic push;
    logic do_pop;

    always_comb
    begin
        in_entry.is_block = (aesbc_pkg::opcode_t'(opcode) == aesbc_pkg::OP_BLOCK);
        in_entry.key_ok   = (round_index <= 4'(aesbc_pkg::MAX_ROUNDS));
        in_entry.idx      = aesbc_pkg::KEY_AW'(round_index);
        in_entry.first    = first_block;
        in_entry.data     = {word_high, word_low};
    end

    assign in_ready = (cnt_reg != CW'(aesbc_pkg::QUEUE_DEPTH));
    assign push     = in_valid && in_ready;
    assign do_pop   = pop && (cnt_reg != '0);

    always_comb
    begin
        wr_ptr_next = push ? PW'(wr_ptr_reg + 1'b1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? PW'(rd_ptr_reg + 1'b1) : rd_ptr_reg;
        cnt_next    = CW'(cnt_reg + CW'(push) - CW'(do_pop));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= in_entry;
        end
    end

    assign item.valid = (cnt_reg != '0);
    assign item.entry = mem_reg[rd_ptr_reg];
endmodule
`default_nettype wire

[rtl/core/aesbc_engine.sv]
// Back end: key table writes and round-per-cycle block processing with chaining.
`default_nettype none
module aesbc_engine (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire aesbc_pkg::cfg_t      cfg,
    input  wire aesbc_pkg::item_t     item,
    output logic                      pop,
    output aesbc_pkg::eng_status_t    status,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic [63:0]               result_high,
    output logic [63:0]               result_low
);
    localparam int AW = aesbc_pkg::KEY_AW;
    localparam int RW = aesbc_pkg::RND_W;

    typedef enum logic [1:0] {S_IDLE, S_RUN, S_FIN} state_t;

    state_t         state_reg, state_next;
    logic [RW-1:0]  step_reg, step_next;
    logic [RW-1:0]  nr_reg, nr_next;
    logic           dec_reg, dec_next;
    logic           cbce_reg, cbce_next;
    logic           out_valid_reg, out_valid_next;
    logic [127:0]   s_reg, s_next;
    logic [127:0]   orig_reg, orig_next;
    logic [127:0]   cv_reg, cv_next;
    logic [127:0]   res_reg, res_next;

    logic [RW-1:0]  nr_eff;
    logic [RW-1:0]  kn;
    logic [AW-1:0]  raddr;
    logic [127:0]   rk;
    logic [127:0]   cv_use;
    logic [127:0]   t;
    logic           is_dec, is_cbce, last, out_free, key_we;

    aesbc_ram #(.WIDTH(128), .DEPTH(aesbc_pkg::KEY_SLOTS)) u_keys (
        .clk   (clk),
        .we    (key_we),
        .waddr (item.entry.idx),
        .wdata (item.entry.data),
        .raddr (raddr),
        .rdata (rk)
    );

    always_comb
    begin
        if (cfg.num_rounds == '0)
            nr_eff = RW'(1);
        else if (cfg.num_rounds > RW'(aesbc_pkg::MAX_ROUNDS))
            nr_eff = RW'(aesbc_pkg::MAX_ROUNDS);
        else
            nr_eff = cfg.num_rounds;
    end

    assign is_dec  = (aesbc_pkg::mode_t'(cfg.mode) == aesbc_pkg::MODE_CBC_DEC);
    assign is_cbce = (aesbc_pkg::mode_t'(cfg.mode) == aesbc_pkg::MODE_CBC_ENC);
    assign cv_use  = item.entry.first ? cfg.iv : cv_reg;
    assign pop     = (state_reg == S_IDLE) && item.valid;
    assign key_we  = pop && !item.entry.is_block && item.entry.key_ok;
    assign kn      = RW'(step_reg + 1'b1);
    assign last    = (step_reg == nr_reg);
    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        nr_next        = nr_reg;
        dec_next       = dec_reg;
        cbce_next      = cbce_reg;
        out_valid_next = out_valid_reg && !out_ready;
        s_next         = s_reg;
        orig_next      = orig_reg;
        cv_next        = cv_reg;
        res_next       = res_reg;
        raddr          = '0;
        t              = '0;
        case (state_reg)
            S_IDLE:
            begin
                raddr = is_dec ? AW'(nr_eff) : '0;
                if (pop && item.entry.is_block)
                begin
                    state_next = S_RUN;
                    step_next  = '0;
                    nr_next    = nr_eff;
                    dec_next   = is_dec;
                    cbce_next  = is_cbce;
                    orig_next  = item.entry.data;
                    s_next     = is_cbce ? (item.entry.data ^ cv_use) : item.entry.data;
                    if (is_dec || is_cbce)
                    begin
                        cv_next = cv_use;
                    end
                end
            end
            S_RUN:
            begin
                // Fetch the key for the following step ahead of that step, through the registered RAM read.
                if (!last)
                    raddr = dec_reg ? AW'(nr_reg - kn) : AW'(kn);
                if (step_reg == '0)
                begin
                    s_next = s_reg ^ rk;
                end
                else if (dec_reg)
                begin
                    t      = aesbc_pkg::inv_sub_shift(s_reg) ^ rk;
                    s_next = last ? t : aesbc_pkg::mix(t, 1'b1);
                end
                else
                begin
                    t      = aesbc_pkg::sub_shift(s_reg);
                    s_next = (last ? t : aesbc_pkg::mix(t, 1'b0)) ^ rk;
                end
                step_next = kn;
                if (last)
                    state_next = S_FIN;
            end
            S_FIN:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    res_next       = dec_reg ? (s_reg ^ cv_reg) : s_reg;
                    if (dec_reg)
                        cv_next = orig_reg;
                    else if (cbce_reg)
                        cv_next = s_reg;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            step_reg      <= '0;
            nr_reg        <= '0;
            dec_reg       <= 1'b0;
            cbce_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            cv_reg        <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            nr_reg        <= nr_next;
            dec_reg       <= dec_next;
            cbce_reg      <= cbce_next;
            out_valid_reg <= out_valid_next;
            cv_reg        <= cv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s_reg    <= s_next;
        orig_reg <= orig_next;
        res_reg  <= res_next;
    end

    assign out_valid   = out_valid_reg;
    assign result_high = res_reg[127:64];
    assign result_low  = res_reg[63:0];

    assign status.busy      = (state_reg != S_IDLE);
    assign status.pop       = pop;
    assign status.pop_block = pop && item.entry.is_block;
endmodule
`default_nettype wire

[rtl/core/aes_block_cipher_cbc_ecb_core.sv]
// AES-128/192/256 block engine, ECB and CBC modes: top level.
//
// Input channel (in_valid/in_ready) carries one word per transfer: opcode 0
// writes word_high/word_low into round key slot round_index (slots above 14
// are dropped), opcode 1 processes one 128-bit block. A two-word queue sits
// between the front end and the engine, so the input keeps taking words
// while the engine works or a result waits.
// Output channel (out_valid/out_ready) returns one word per block.
// A block passes through the engine in steps, N the round count (1 to 14):
// it leaves the queue as the first key is fetched, the initial key is
// added, N rounds run one per cycle through the shared round unit, and the
// result is handed off into the output register. A key write is done as the
// key leaves the queue. Blocks are handled one at a time.
// Configuration: cfg_we/cfg_index/cfg_data, index 0 mode, 1 round count,
// 2 IV high, 3 IV low. Write only while the block is idle.
// Reset clears the queue, the engine state, the output valid and the chaining
// value, sets ECB, 10 rounds, zero IV; the key table holds no reset value.
// A stalled receiver holds the result; the engine then waits before the
// next result, and the queue fills and drops in_ready.
`default_nettype none
module aes_block_cipher_cbc_ecb_core (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [63:0] cfg_data,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic        opcode,
    input  wire logic [3:0]  round_index,
    input  wire logic        first_block,
    input  wire logic [63:0] word_high,
    input  wire logic [63:0] word_low,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [63:0]      result_high,
    output logic [63:0]      result_low
);
    logic [1:0]                   mode_reg;
    logic [aesbc_pkg::RND_W-1:0]  rounds_reg;
    logic [63:0]                  iv_high_reg;
    logic [63:0]                  iv_low_reg;
    aesbc_pkg::cfg_t              cfg;
    aesbc_pkg::item_t             item;
    aesbc_pkg::eng_status_t       status;
    logic                         pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= 2'(aesbc_pkg::MODE_ECB);
            rounds_reg  <= aesbc_pkg::RND_W'(10);
            iv_high_reg <= '0;
            iv_low_reg  <= '0;
        end
        else if (cfg_we)
        begin
            case (aesbc_pkg::cfg_index_t'(cfg_index))
                aesbc_pkg::CFG_MODE:    mode_reg    <= cfg_data[1:0];
                aesbc_pkg::CFG_ROUNDS:  rounds_reg  <= cfg_data[aesbc_pkg::RND_W-1:0];
                aesbc_pkg::CFG_IV_HIGH: iv_high_reg <= cfg_data;
                aesbc_pkg::CFG_IV_LOW:  iv_low_reg  <= cfg_data;
                default:                mode_reg    <= mode_reg;
            endcase
        end
    end

    assign cfg.mode       = mode_reg;
    assign cfg.num_rounds = rounds_reg;
    assign cfg.iv         = {iv_high_reg, iv_low_reg};

    aesbc_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .opcode      (opcode),
        .round_index (round_index),
        .first_block (first_block),
        .word_high   (word_high),
        .word_low    (word_low),
        .item        (item),
        .pop         (pop)
    );

    aesbc_engine u_engine (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .item        (item),
        .pop         (pop),
        .status      (status),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .result_high (result_high),
        .result_low  (result_low)
    );

`ifndef ASSERT_OFF
    a_pop_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
        status.pop |-> item.valid)
        else $error("engine popped an empty queue");

    a_block_starts_run: assert property (@(posedge clk) disable iff (!rst_n)
        status.pop_block |=> status.busy)
        else $error("block taken but engine not busy");

    a_no_pop_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        status.busy |-> !status.pop)
        else $error("engine popped while processing a block");
`endif
endmodule
`default_nettype wire

[test/aes_block_cipher_cbc_ecb_core_checker.sv]
// Watches both channels of the AES block engine, predicts each result and compares.
module aes_block_cipher_cbc_ecb_core_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [63:0] cfg_data,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic        opcode,
    input  logic [3:0]  round_index,
    input  logic        first_block,
    input  logic [63:0] word_high,
    input  logic [63:0] word_low,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [63:0] result_high,
    input  logic [63:0] result_low,
    output int          fail_count,
    output int          pending
);

    logic [7:0]   fwd_sbox [256];
    logic [7:0]   rev_sbox [256];
    logic [127:0] key_slot [aesbc_pkg::KEY_SLOTS];
    logic [127:0] chain;
    logic [1:0]   cur_mode;
    logic [3:0]   cur_rounds;
    logic [63:0]  cur_iv_high;
    logic [63:0]  cur_iv_low;
    logic [127:0] expected_blocks [$];

    assign pending = expected_blocks.size();

    initial
    begin
        logic [7:0] tbl [256];
        tbl = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
        };
        for (int i = 0; i < 256; i++)
        begin
            fwd_sbox[i] = tbl[i];
            rev_sbox[tbl[i]] = 8'(i);
        end
    end

    function automatic logic [7:0] gf_double(input logic [7:0] b);
        return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] k);
        logic [7:0] acc;
        acc = 8'h00;
        for (int i = 0; i < 8; i++)
        begin
            if (k[i])
                acc ^= a;
            a = gf_double(a);
        end
        return acc;
    endfunction

    // Byte 0 of the state sits in the top bits.
    function automatic logic [7:0] byte_at(input logic [127:0] s, input int i);
        return s[127-8*i -: 8];
    endfunction

    function automatic logic [127:0] subst_rows(input logic [127:0] s, input bit rev);
        logic [127:0] t;
        t = '0;
        for (int c = 0; c < 4; c++)
        begin
            for (int r = 0; r < 4; r++)
            begin
                if (rev)
                    t[127-8*(r+4*((c+r)%4)) -: 8] = rev_sbox[byte_at(s, r+4*c)];
                else
                    t[127-8*(r+4*c) -: 8] = fwd_sbox[byte_at(s, r+4*((c+r)%4))];
            end
        end
        return t;
    endfunction

    function automatic logic [127:0] mix_columns(input logic [127:0] s, input bit rev);
        logic [127:0] t;
        logic [7:0]   k [4];
        logic [7:0]   a [4];
        t = '0;
        if (rev)
            k = '{8'd14, 8'd11, 8'd13, 8'd9};
        else
            k = '{8'd2, 8'd3, 8'd1, 8'd1};
        for (int c = 0; c < 4; c++)
        begin
            for (int r = 0; r < 4; r++)
                a[r] = byte_at(s, r+4*c);
            for (int r = 0; r < 4; r++)
                t[127-8*(r+4*c) -: 8] = gf_mul(a[r], k[0]) ^ gf_mul(a[(r+1)%4], k[1])
                                      ^ gf_mul(a[(r+2)%4], k[2]) ^ gf_mul(a[(r+3)%4], k[3]);
        end
        return t;
    endfunction

    function automatic int rounds_in_use();
        int n;
        n = cur_rounds;
        if (n < 1)
            n = 1;
        if (n > aesbc_pkg::MAX_ROUNDS)
            n = aesbc_pkg::MAX_ROUNDS;
        return n;
    endfunction

    function automatic logic [127:0] aes_encrypt(input logic [127:0] s);
        int n;
        n = rounds_in_use();
        s ^= key_slot[0];
        for (int r = 1; r < n; r++)
            s = mix_columns(subst_rows(s, 1'b0), 1'b0) ^ key_slot[r];
        return subst_rows(s, 1'b0) ^ key_slot[n];
    endfunction

    function automatic logic [127:0] aes_decrypt(input logic [127:0] s);
        int n;
        n = rounds_in_use();
        s ^= key_slot[n];
        for (int r = n - 1; r > 0; r--)
            s = mix_columns(subst_rows(s, 1'b1) ^ key_slot[r], 1'b1);
        return subst_rows(s, 1'b1) ^ key_slot[0];
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        logic [127:0] blk;
        logic [127:0] res;
        if (!rst_n)
        begin
            chain       <= '0;
            cur_mode    <= aesbc_pkg::MODE_ECB;
            cur_rounds  <= 4'd10;
            cur_iv_high <= '0;
            cur_iv_low  <= '0;
            fail_count  <= 0;
            expected_blocks.delete();
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    aesbc_pkg::CFG_MODE:    cur_mode    <= cfg_data[1:0];
                    aesbc_pkg::CFG_ROUNDS:  cur_rounds  <= cfg_data[3:0];
                    aesbc_pkg::CFG_IV_HIGH: cur_iv_high <= cfg_data;
                    aesbc_pkg::CFG_IV_LOW:  cur_iv_low  <= cfg_data;
                    default: ;
                endcase
            end
            if (in_valid && in_ready)
            begin
                blk = {word_high, word_low};
                if (opcode == aesbc_pkg::OP_KEY)
                begin
                    if (round_index <= aesbc_pkg::MAX_ROUNDS)
                        key_slot[round_index] = blk;
                end
                else
                begin
                    res = chain;
                    if ((cur_mode == aesbc_pkg::MODE_CBC_ENC
                         || cur_mode == aesbc_pkg::MODE_CBC_DEC) && first_block)
                        res = {cur_iv_high, cur_iv_low};
                    if (cur_mode == aesbc_pkg::MODE_CBC_ENC)
                    begin
                        res = aes_encrypt(blk ^ res);
                        chain <= res;
                    end
                    else if (cur_mode == aesbc_pkg::MODE_CBC_DEC)
                    begin
                        res = aes_decrypt(blk) ^ res;
                        chain <= blk;
                    end
                    else
                        res = aes_encrypt(blk);
                    expected_blocks.push_back(res);
                end
            end
            if (out_valid && out_ready)
            begin
                if (expected_blocks.size() == 0)
                begin
                    $error("result word with nothing expected: %h %h", result_high, result_low);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    res = expected_blocks.pop_front();
                    if (result_high !== res[127:64])
                        $error("result_high expected %h actual %h", res[127:64], result_high);
                    if (result_low !== res[63:0])
                        $error("result_low expected %h actual %h", res[63:0], result_low);
                    if (result_high !== res[127:64] || result_low !== res[63:0])
                        fail_count <= fail_count + 1;
                end
            end
        end
    end

endmodule

[test/aes_block_cipher_cbc_ecb_core_tb.sv]
// Stimulus and verdict for the AES block engine testbench.
module aes_block_cipher_cbc_ecb_core_tb;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = aesbc_pkg::CFG_MODE;
    logic [63:0] cfg_data = '0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic        opcode = aesbc_pkg::OP_KEY;
    logic [3:0]  round_index = '0;
    logic        first_block = 1'b0;
    logic [63:0] word_high = '0;
    logic [63:0] word_low = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [63:0] result_high;
    logic [63:0] result_low;
    int          fail_count;
    int          pending;
    int          cycle_count = 0;
    int          rnd_pick_list [6] = '{0, 1, 12, 14, 15, 10};

    localparam int CYCLE_LIMIT = 600000;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    aes_block_cipher_cbc_ecb_core uut (.*);

    aes_block_cipher_cbc_ecb_core_checker chk (.*);

    function automatic int gap_len();
        int p;
        p = $urandom_range(99);
        if (p < 45)
            return 0;
        if (p < 92)
            return $urandom_range(3, 1);
        return $urandom_range(40, 8);
    endfunction

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Receiver: random stalls, with quiet stretches of none.
    initial
    begin
        int stall;
        stall = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                stall = stall - 1;
            end
            else
            begin
                out_ready <= 1'b1;
                if (out_valid && out_ready && ($urandom_range(3) != 0))
                    stall = gap_len();
            end
        end
    end

    // Valid stays high into the next word when no gap follows.
    task automatic send_word(input logic op, input logic [3:0] idx, input logic first,
                             input logic [63:0] hi, input logic [63:0] lo, input bit gaps);
        int g;
        g = gaps ? gap_len() : 0;
        if (g > 0)
        begin
            in_valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        in_valid    <= 1'b1;
        opcode      <= op;
        round_index <= idx;
        first_block <= first;
        word_high   <= hi;
        word_low    <= lo;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_reg(input aesbc_pkg::cfg_index_t idx, input logic [63:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    task automatic load_keys();
        for (int i = 0; i < aesbc_pkg::KEY_SLOTS; i++)
            send_word(aesbc_pkg::OP_KEY, 4'(i), 1'($urandom_range(1)),
                      rand64(), rand64(), 1'b1);
    endtask

    initial
    begin
        logic [1:0] mode_pick;
        logic [3:0] rnd_pick;
        int msg_len;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: all slots, data extremes, every mode, rounds 0,1,10,12,14,15.
        write_reg(aesbc_pkg::CFG_IV_HIGH, '1);
        write_reg(aesbc_pkg::CFG_IV_LOW, '0);
        send_word(aesbc_pkg::OP_KEY, 4'd0, 1'b0, '1, '1, 1'b0);
        for (int i = 1; i < aesbc_pkg::KEY_SLOTS; i++)
            send_word(aesbc_pkg::OP_KEY, 4'(i), 1'b1, rand64(), rand64(), 1'b0);
        send_word(aesbc_pkg::OP_KEY, 4'd15, 1'b1, '1, '1, 1'b0);
        send_word(aesbc_pkg::OP_BLOCK, 4'd15, 1'b0, '0, '0, 1'b0);
        send_word(aesbc_pkg::OP_BLOCK, 4'd0, 1'b1, '1, '1, 1'b0);
        for (int m = 0; m < 4; m++)
        begin
            drain();
            write_reg(aesbc_pkg::CFG_MODE, 64'(m));
            send_word(aesbc_pkg::OP_BLOCK, 4'd0, 1'b1, rand64(), rand64(), 1'b0);
            send_word(aesbc_pkg::OP_BLOCK, 4'd0, 1'b0, rand64(), rand64(), 1'b0);
        end
        foreach (rnd_pick_list[i])
        begin
            drain();
            write_reg(aesbc_pkg::CFG_ROUNDS, 64'(rnd_pick_list[i]));
            send_word(aesbc_pkg::OP_BLOCK, 4'd0, 1'b1, rand64(), rand64(), 1'b0);
        end

        // Random: messages in any mode, some noise; reconfigure between phases.
        for (int ph = 0; ph < 24; ph++)
        begin
            drain();
            mode_pick = (ph < 4) ? 2'(ph) : 2'($urandom_range(3));
            if ($urandom_range(4) == 0)
                rnd_pick = 4'($urandom_range(15));
            else
                rnd_pick = 4'(10 + 2 * $urandom_range(2));
            if (ph == 4)
                rnd_pick = 4'd14;
            write_reg(aesbc_pkg::CFG_MODE, {62'd0, mode_pick});
            write_reg(aesbc_pkg::CFG_ROUNDS, {60'd0, rnd_pick});
            write_reg(aesbc_pkg::CFG_IV_HIGH, rand64());
            write_reg(aesbc_pkg::CFG_IV_LOW, rand64());
            if ($urandom_range(2) == 0)
                load_keys();
            for (int k = 0; k < 60; k++)
            begin
                if ($urandom_range(9) == 0)
                    send_word(aesbc_pkg::OP_KEY, 4'($urandom_range(15)),
                              1'($urandom_range(1)), rand64(), rand64(), 1'b1);
                else
                begin
                    msg_len = $urandom_range(6, 1);
                    for (int b = 0; b < msg_len; b++)
                        send_word(aesbc_pkg::OP_BLOCK, 4'($urandom_range(15)),
                                  (b == 0) ? ($urandom_range(7) != 0) : ($urandom_range(9) == 0),
                                  rand64(), rand64(), 1'b1);
                    k = k + msg_len - 1;
                end
            end
        end
        drain();
        if (fail_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
